// ===== src/wglc_pkg.sv =====
// Package for the water gate level controller: widths, codes, register
// indexes, reset values and gate mask helpers. No dependencies.
`default_nettype none

package wglc_pkg;

    // Gate count and the fixed widths of the item fields.
    localparam int GATES     = 4;
    localparam int MASK_W    = 4;
    localparam int OP_W      = 3;
    localparam int DIST_W    = 13;
    localparam int IDX_W     = 3;
    localparam int REF_W     = 16;
    localparam int LEVEL_W   = 17;
    localparam int SEC_W     = 16;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 17;

    typedef logic [GATES-1:0] gate_vec_t;
    typedef logic [MASK_W-1:0] mask_t;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_MEASURE = 3'd1;
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLOSE   = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

    // Automatic action codes.
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

    // Status codes.
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_BAD_GATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_REF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_REF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_MASK = 3'd6;

    // Configuration reset values.
    localparam logic signed [REF_W-1:0]   RST_MAIN_REF  = 16'sd3000;
    localparam logic signed [REF_W-1:0]   RST_SEC_REF   = 16'sd3000;
    localparam logic signed [LEVEL_W-1:0] RST_UPPER     = -17'sd400;
    localparam logic signed [LEVEL_W-1:0] RST_LOWER     = -17'sd600;
    localparam logic [SEC_W-1:0]          RST_DELAY     = 16'd60;
    localparam logic                      RST_AUTO      = 1'b0;
    localparam logic [MASK_W-1:0]         RST_GATE_MASK = 4'd1;

    localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

    // Gate vector to the four-bit field, dropping or zero-filling gates.
    function automatic mask_t gates_to_mask(input gate_vec_t v);
        logic [15:0] w;
        begin
            w = 16'(v);
            return w[MASK_W-1:0];
        end
    endfunction

    // Four-bit field to a gate vector.
    function automatic gate_vec_t mask_to_gates(input mask_t m);
        logic [15:0] w;
        begin
            w = 16'(m);
            return w[GATES-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/wglc_if.sv =====
// Valid/ready channel interfaces for the input items and result items of
// the water gate level controller. Depends on wglc_pkg.
`default_nettype none

interface wglc_in_if import wglc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [DIST_W-1:0]   main_distance;
    logic [DIST_W-1:0]   secondary_distance;
    logic [IDX_W-1:0]    gate_index;

    modport source (output valid, op, main_distance, secondary_distance, gate_index,
                    input ready);
    modport sink (input valid, op, main_distance, secondary_distance, gate_index,
                  output ready);
endinterface

interface wglc_out_if import wglc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [MASK_W-1:0]          open_drive_mask;
    logic [MASK_W-1:0]          close_drive_mask;
    logic [MASK_W-1:0]          open_state_mask;
    logic signed [LEVEL_W-1:0]  main_level;
    logic signed [LEVEL_W-1:0]  secondary_level;
    logic [ACT_W-1:0]           auto_action;
    logic                       status;

    modport source (output valid, open_drive_mask, close_drive_mask, open_state_mask,
                    main_level, secondary_level, auto_action, status,
                    input ready);
    modport sink (input valid, open_drive_mask, close_drive_mask, open_state_mask,
                  main_level, secondary_level, auto_action, status,
                  output ready);
endinterface

`default_nettype wire

// ===== src/water_gate_level_controller_unit.sv =====
// Water gate level controller top level: input register, level and gate
// logic, result register. Depends on wglc_pkg and the wglc_if interfaces.
//
// The block takes one item per clock cycle while the result side is ready and
// returns one result for each item through the input register and the result
// register. An item is first held in the input register; once the result
// register is free, the level, gate and timer state is updated from it and
// the result register is loaded with the state after the update, so each
// item sees everything that the items before it left. A stalled result holds
// the input register, and the block then takes no new item until the result
// is transferred. The user writes configuration through cfg_write, cfg_index
// and cfg_data only while no item is in flight; the block does not enforce it.
`default_nettype none

module water_gate_level_controller_unit
    import wglc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    wglc_in_if.sink                   item,
    wglc_out_if.source                result
);

    // Configuration registers.
    logic signed [REF_W-1:0]   main_ref_reg;
    logic signed [REF_W-1:0]   sec_ref_reg;
    logic signed [LEVEL_W-1:0] upper_reg;
    logic signed [LEVEL_W-1:0] lower_reg;
    logic [SEC_W-1:0]          delay_reg;
    logic                      auto_reg;
    logic [MASK_W-1:0]         gate_mask_reg;

    // Controller state.
    logic signed [LEVEL_W-1:0] main_level_reg,  main_level_next;
    logic signed [LEVEL_W-1:0] sec_level_reg,   sec_level_next;
    gate_vec_t                 open_bits_reg,   open_bits_next;
    gate_vec_t                 moving_bits_reg, moving_bits_next;
    logic [SEC_W-1:0]          seconds_reg,     seconds_next;

    // Input register.
    logic                s1_valid_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic [DIST_W-1:0]   s1_md_reg;
    logic [DIST_W-1:0]   s1_sd_reg;
    logic [IDX_W-1:0]    s1_gi_reg;

    // Result register.
    logic                      out_valid_reg;
    logic [MASK_W-1:0]         out_open_drive_reg;
    logic [MASK_W-1:0]         out_close_drive_reg;
    logic [MASK_W-1:0]         out_open_state_reg;
    logic signed [LEVEL_W-1:0] out_main_level_reg;
    logic signed [LEVEL_W-1:0] out_sec_level_reg;
    logic [ACT_W-1:0]          out_action_reg;
    logic                      out_status_reg;

    logic       advance;
    logic       out_load;
    logic [ACT_W-1:0] action_next;
    logic       status_next;

    logic [SEC_W-1:0] sec_inc;
    logic       rules_on;
    logic       open_rule;
    logic       close_rule;
    gate_vec_t  enabled;
    gate_vec_t  idle;
    gate_vec_t  sel_open;
    gate_vec_t  sel_close;
    gate_vec_t  gate_bit;
    logic       gate_missing;

    // Handshake: the result register frees when empty or transferred.
    assign advance    = !out_valid_reg || result.ready;
    assign out_load   = s1_valid_reg && advance;
    assign item.ready = !s1_valid_reg || advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_ref_reg  <= RST_MAIN_REF;
            sec_ref_reg   <= RST_SEC_REF;
            upper_reg     <= RST_UPPER;
            lower_reg     <= RST_LOWER;
            delay_reg     <= RST_DELAY;
            auto_reg      <= RST_AUTO;
            gate_mask_reg <= RST_GATE_MASK;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAIN_REF:  main_ref_reg  <= cfg_data[REF_W-1:0];
                REG_SEC_REF:   sec_ref_reg   <= cfg_data[REF_W-1:0];
                REG_UPPER:     upper_reg     <= cfg_data[LEVEL_W-1:0];
                REG_LOWER:     lower_reg     <= cfg_data[LEVEL_W-1:0];
                REG_DELAY:     delay_reg     <= cfg_data[SEC_W-1:0];
                REG_AUTO:      auto_reg      <= cfg_data[0];
                REG_GATE_MASK: gate_mask_reg <= cfg_data[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input register: loads whenever the block is ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_op_reg <= item.op;
            s1_md_reg <= item.main_distance;
            s1_sd_reg <= item.secondary_distance;
            s1_gi_reg <= item.gate_index;
        end
    end

    // Level rules on the stored levels, with the timer after this tick.
    always_comb
    begin
        sec_inc    = (seconds_reg == SEC_MAX) ? seconds_reg : seconds_reg + 1'b1;
        rules_on   = auto_reg && (sec_inc >= delay_reg);
        open_rule  = ((main_level_reg > upper_reg) && (sec_level_reg < main_level_reg)) ||
                     ((main_level_reg < lower_reg) && (sec_level_reg > main_level_reg));
        close_rule = (main_level_reg > lower_reg) && (main_level_reg < upper_reg);
        enabled    = mask_to_gates(gate_mask_reg);
        idle       = ~moving_bits_reg;
        sel_open   = enabled & idle & ~open_bits_reg;
        sel_close  = enabled & idle & open_bits_reg;
        gate_bit   = gate_vec_t'(1'b1) << s1_gi_reg;
        gate_missing = ({1'b0, s1_gi_reg} >= (IDX_W + 1)'(GATES));
    end

    // Next state and result for the item in the input register.
    always_comb
    begin
        main_level_next  = main_level_reg;
        sec_level_next   = sec_level_reg;
        open_bits_next   = open_bits_reg;
        moving_bits_next = moving_bits_reg;
        seconds_next     = seconds_reg;
        action_next      = ACT_NONE;
        status_next      = ST_OK;

        case (s1_op_reg)
            OP_TICK:
            begin
                seconds_next = sec_inc;
                if (rules_on && open_rule)
                begin
                    open_bits_next   = open_bits_reg | sel_open;
                    moving_bits_next = moving_bits_reg | sel_open;
                    seconds_next     = '0;
                    action_next      = ACT_OPEN;
                end
                else if (rules_on && close_rule)
                begin
                    open_bits_next   = open_bits_reg & ~sel_close;
                    moving_bits_next = moving_bits_reg | sel_close;
                    seconds_next     = '0;
                    action_next      = ACT_CLOSE;
                end
            end
            OP_MEASURE:
            begin
                // A zero distance means no reading and keeps the old level.
                if (s1_md_reg != '0)
                begin
                    main_level_next = LEVEL_W'(main_ref_reg) -
                                      $signed({{(LEVEL_W-DIST_W){1'b0}}, s1_md_reg});
                end
                if (s1_sd_reg != '0)
                begin
                    sec_level_next = LEVEL_W'(sec_ref_reg) -
                                     $signed({{(LEVEL_W-DIST_W){1'b0}}, s1_sd_reg});
                end
            end
            OP_OPEN, OP_CLOSE, OP_STOP:
            begin
                if (gate_missing)
                begin
                    status_next = ST_BAD_GATE;
                end
                else if (s1_op_reg == OP_OPEN)
                begin
                    open_bits_next   = open_bits_reg | gate_bit;
                    moving_bits_next = moving_bits_reg | gate_bit;
                end
                else if (s1_op_reg == OP_CLOSE)
                begin
                    open_bits_next   = open_bits_reg & ~gate_bit;
                    moving_bits_next = moving_bits_reg | gate_bit;
                end
                else
                begin
                    moving_bits_next = moving_bits_reg & ~gate_bit;
                end
            end
            default:
            begin
                // Unknown operation: report the state unchanged.
            end
        endcase
    end

    // State update, once per item as it moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_level_reg  <= '0;
            sec_level_reg   <= '0;
            open_bits_reg   <= '0;
            moving_bits_reg <= '0;
            seconds_reg     <= '0;
        end
        else if (out_load)
        begin
            main_level_reg  <= main_level_next;
            sec_level_reg   <= sec_level_next;
            open_bits_reg   <= open_bits_next;
            moving_bits_reg <= moving_bits_next;
            seconds_reg     <= seconds_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_open_drive_reg  <= gates_to_mask(moving_bits_next & open_bits_next);
            out_close_drive_reg <= gates_to_mask(moving_bits_next & ~open_bits_next);
            out_open_state_reg  <= gates_to_mask(open_bits_next);
            out_main_level_reg  <= main_level_next;
            out_sec_level_reg   <= sec_level_next;
            out_action_reg      <= action_next;
            out_status_reg      <= status_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.open_drive_mask  = out_open_drive_reg;
    assign result.close_drive_mask = out_close_drive_reg;
    assign result.open_state_mask  = out_open_state_reg;
    assign result.main_level       = out_main_level_reg;
    assign result.secondary_level  = out_sec_level_reg;
    assign result.auto_action      = out_action_reg;
    assign result.status           = out_status_reg;

`ifndef NO_ASSERTIONS
    // The input side stalls only behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (out_valid_reg && !result.ready))
        else $error("input stalled without a waiting result");

    // An automatic action restarts the seconds count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && action_next != ACT_NONE) |=> (seconds_reg == '0))
        else $error("seconds count not restarted after an automatic action");

    // Only a tick can report an automatic action.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s1_op_reg != OP_TICK) |-> (action_next == ACT_NONE))
        else $error("automatic action reported for an item that is not a tick");

    // The state moves only when a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_load) |-> ($stable(open_bits_reg) && $stable(moving_bits_reg)))
        else $error("gate state changed without an item");
`endif

endmodule

`default_nettype wire
